### hw/rtl/bounded_position_deque_assert.svh
// Assertion macros shared by the deque checker.
// Each macro samples on the rising edge of clk and is quiet while rst is high.
`ifndef BOUNDED_POSITION_DEQUE_ASSERT_SVH
`define BOUNDED_POSITION_DEQUE_ASSERT_SVH

// Same-cycle implication.
`define BPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bpd_pkg.sv
package bpd_pkg;

  // Default sizes.
  localparam int DEPTH_DEF      = 256;
  localparam int COORD_BITS_DEF = 8;

  // Stream word widths.
  localparam int IN_W  = 40;
  localparam int OUT_W = 88;

  // Input word layout.
  localparam int IN_CMD_LO = 0;
  localparam int IN_X_LO   = 3;
  localparam int IN_Y_LO   = 11;
  localparam int IN_SYM_LO = 19;
  localparam int IN_IDX_LO = 27;

  // Output word layout.
  localparam int OUT_STATUS_LO = 0;
  localparam int OUT_SIZE_LO   = 2;
  localparam int OUT_ELEM_LO   = 11;
  localparam int OUT_HEAD_LO   = 35;
  localparam int OUT_TAIL_LO   = 59;
  localparam int OUT_USED_W    = 83;

  // Commands.
  localparam logic [2:0] CMD_INS_HEAD = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL = 3'd1;
  localparam logic [2:0] CMD_RM_HEAD  = 3'd2;
  localparam logic [2:0] CMD_RM_TAIL  = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // What a cell loads in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_WRITE_AT
  } cell_op_t;

  // Assemble one result word from its fields.
  function automatic logic [OUT_W-1:0] pack_result(
    input logic [1:0] status,
    input logic [8:0] size,
    input logic [7:0] ex, input logic [7:0] ey, input logic [7:0] es,
    input logic [7:0] hx, input logic [7:0] hy, input logic [7:0] hs,
    input logic [7:0] tx, input logic [7:0] ty, input logic [7:0] ts
  );
    return {5'd0, ts, ty, tx, hs, hy, hx, es, ey, ex, size, status};
  endfunction

endpackage

### hw/rtl/bpd_cell.sv
module bpd_cell #(
  parameter int ENTRY_W = 24,
  parameter int CNT_W   = 9,
  parameter int IDX     = 0
) (
  input  logic               clk,
  input  bpd_pkg::cell_op_t  op,
  input  logic [CNT_W-1:0]   count,
  input  logic [ENTRY_W-1:0] item,
  input  logic [ENTRY_W-1:0] left_entry,
  input  logic [ENTRY_W-1:0] right_entry,
  output logic [ENTRY_W-1:0] entry
);
  import bpd_pkg::*;

  logic               hit;
  logic [ENTRY_W-1:0] entry_next;

  // This cell is the first free slot when its position equals the count.
  assign hit = (count == CNT_W'(IDX));

  // Pick what the cell holds next.
  always_comb begin
    entry_next = entry;
    unique case (op)
      CELL_HOLD:       entry_next = entry;
      CELL_FROM_LEFT:  entry_next = left_entry;
      CELL_FROM_RIGHT: entry_next = right_entry;
      CELL_WRITE_AT:   entry_next = hit ? item : entry;
      default:         entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### hw/rtl/bounded_position_deque.sv
// Bounded deque of (x, y, symbol) entries held in a row of DEPTH cells, the
// head entry in the first cell.
// Input words arrive on s_tvalid/s_tready/s_tdata, one command per word.
// Each command gives exactly one result word on m_tvalid/m_tready/m_tdata.
// Insert at head, insert at tail, remove head, a command that fails or is
// unknown, and remove tail that empties the list are handled in the cycle
// of acceptance: the result is registered and shown in the next cycle, and
// the next word can be taken as that result leaves.
// Read by index, and remove tail that leaves one or more entries, rotate the
// whole row of cells once round, one cell per cycle, to reach the wanted
// entry. No word is taken until the rotation ends; its result is then registered.
// Reset empties the list at once; no clearing pass is needed, as cells past
// the count are never shown.
// A result waits in the output register while m_tready is low; no new word
// is taken until that result has been taken.
module bounded_position_deque #(
  parameter int DEPTH      = bpd_pkg::DEPTH_DEF,
  parameter int COORD_BITS = bpd_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // cmd[2:0], in_x[10:3], in_y[18:11], in_symbol[26:19], read_index[36:27]
  input  logic [bpd_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status[1:0], size[10:2], elem_x, elem_y, elem_symbol, head_x, head_y,
  // head_symbol, tail_x, tail_y, tail_symbol (8 bits each from bit 11 up)
  output logic [bpd_pkg::OUT_W-1:0] m_tdata
);
  import bpd_pkg::*;

  localparam int ENTRY_W = 2 * COORD_BITS + 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CMP_W   = (CNT_W > 9) ? CNT_W : 9;

  typedef enum logic {ST_IDLE, ST_SWEEP} state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   step;
  logic [IDX_W-1:0]   target;
  logic               sweep_read;
  logic [ENTRY_W-1:0] head;
  logic [ENTRY_W-1:0] tail;
  logic [ENTRY_W-1:0] capture;
  logic [ENTRY_W-1:0] cells [DEPTH];

  // Decoded input word.
  logic [2:0]         cmd;
  logic [ENTRY_W-1:0] item;
  logic [9:0]         read_index;
  logic               accept;

  // Command decode results.
  logic [1:0]         status_c;
  logic [CNT_W-1:0]   count_next;
  logic [ENTRY_W-1:0] head_next;
  logic [ENTRY_W-1:0] tail_next;
  logic               go_sweep;
  logic               go_read;
  logic [IDX_W-1:0]   tgt_c;
  cell_op_t           op;
  logic               full;
  logic               empty;
  logic [CMP_W-1:0]   raw_ext;
  logic               last_step;
  logic [ENTRY_W-1:0] cap;
  logic               res_load;

  function automatic logic [7:0] fx(input logic [ENTRY_W-1:0] e);
    return 8'(e[COORD_BITS-1:0]);
  endfunction

  function automatic logic [7:0] fy(input logic [ENTRY_W-1:0] e);
    return 8'(e[2*COORD_BITS-1:COORD_BITS]);
  endfunction

  function automatic logic [7:0] fs(input logic [ENTRY_W-1:0] e);
    return e[ENTRY_W-1 -: 8];
  endfunction

  assign cmd        = s_tdata[IN_CMD_LO +: 3];
  assign read_index = s_tdata[IN_IDX_LO +: 10];
  assign item       = {s_tdata[IN_SYM_LO +: 8],
                       COORD_BITS'(s_tdata[IN_Y_LO +: 8]),
                       COORD_BITS'(s_tdata[IN_X_LO +: 8])};

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign raw_ext = CMP_W'(read_index[8:0]);

  // Work out the effect of the command on the list.
  always_comb begin
    status_c   = STATUS_DONE;
    count_next = count;
    head_next  = head;
    tail_next  = tail;
    go_sweep   = 1'b0;
    go_read    = 1'b0;
    tgt_c      = '0;
    unique case (cmd)
      CMD_INS_HEAD: begin
        if (full) begin
          status_c = STATUS_FULL;
        end else begin
          count_next = count + 1'b1;
          head_next  = item;
          if (empty) tail_next = item;
        end
      end
      CMD_INS_TAIL: begin
        if (full) begin
          status_c = STATUS_FULL;
        end else begin
          count_next = count + 1'b1;
          tail_next  = item;
          if (empty) head_next = item;
        end
      end
      CMD_RM_HEAD: begin
        if (empty) begin
          status_c = STATUS_EMPTY;
        end else begin
          count_next = count - 1'b1;
          head_next  = cells[1];
        end
      end
      CMD_RM_TAIL: begin
        if (empty) begin
          status_c = STATUS_EMPTY;
        end else begin
          count_next = count - 1'b1;
          // The new tail sits two back from the count; fetch it by a sweep.
          if (count != CNT_W'(1)) begin
            go_sweep = 1'b1;
            tgt_c    = IDX_W'(count - CNT_W'(2));
          end
        end
      end
      CMD_READ: begin
        if (empty) begin
          status_c = STATUS_EMPTY;
        end else begin
          go_sweep = 1'b1;
          go_read  = 1'b1;
          // Clamp a negative index to the head and a large one to the tail.
          if (read_index[9]) begin
            tgt_c = '0;
          end else if (raw_ext >= CMP_W'(count)) begin
            tgt_c = IDX_W'(count - 1'b1);
          end else begin
            tgt_c = IDX_W'(raw_ext);
          end
        end
      end
      default: begin
        status_c = STATUS_DONE;
      end
    endcase
  end

  // Drive the row of cells: shift on head insert and removal, write in place on tail insert, rotate in a sweep.
  always_comb begin
    op = CELL_HOLD;
    if (state == ST_SWEEP) begin
      op = CELL_FROM_RIGHT;
    end else if (accept && status_c == STATUS_DONE) begin
      case (cmd)
        CMD_INS_HEAD: op = CELL_FROM_LEFT;
        CMD_INS_TAIL: op = CELL_WRITE_AT;
        CMD_RM_HEAD:  op = CELL_FROM_RIGHT;
        default:      op = CELL_HOLD;
      endcase
    end
  end

  // Row of cells; the last one takes the first one's entry in a rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] left_in;
    logic [ENTRY_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = item;
    end else begin : g_mid_l
      assign left_in = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cells[0];
    end else begin : g_mid_r
      assign right_in = cells[i+1];
    end
    bpd_cell #(
      .ENTRY_W(ENTRY_W),
      .CNT_W  (CNT_W),
      .IDX    (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count),
      .item       (item),
      .left_entry (left_in),
      .right_entry(right_in),
      .entry      (cells[i])
    );
  end

  // After step rotations the first cell holds the entry at that position.
  assign last_step = (step == IDX_W'(DEPTH - 1));
  assign cap       = (step == target) ? cells[0] : capture;

  // A result word is loaded after a direct command or at the end of a sweep.
  assign res_load = (state == ST_IDLE) ? (accept && !go_sweep) : last_step;

  // Sequencer, list registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (go_sweep) begin
              state      <= ST_SWEEP;
              step       <= '0;
              target     <= tgt_c;
              sweep_read <= go_read;
            end else begin
              head     <= head_next;
              tail     <= tail_next;
              if (count_next == '0) begin
                m_tdata <= pack_result(status_c, 9'(count_next), 8'd0, 8'd0, 8'd0,
                                       8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
              end else begin
                m_tdata <= pack_result(status_c, 9'(count_next), 8'd0, 8'd0, 8'd0,
                                       fx(head_next), fy(head_next), fs(head_next),
                                       fx(tail_next), fy(tail_next), fs(tail_next));
              end
            end
          end
        end
        ST_SWEEP: begin
          step    <= step + 1'b1;
          capture <= cap;
          if (last_step) begin
            state    <= ST_IDLE;
            if (sweep_read) begin
              m_tdata <= pack_result(STATUS_DONE, 9'(count), fx(cap), fy(cap), fs(cap),
                                     fx(head), fy(head), fs(head),
                                     fx(tail), fy(tail), fs(tail));
            end else begin
              tail    <= cap;
              m_tdata <= pack_result(STATUS_DONE, 9'(count), 8'd0, 8'd0, 8'd0,
                                     fx(head), fy(head), fs(head),
                                     fx(cap), fy(cap), fs(cap));
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/bpd_check.sv
module bpd_check #(
  parameter int DEPTH = bpd_pkg::DEPTH_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [bpd_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [bpd_pkg::OUT_W-1:0] m_tdata
);
  import bpd_pkg::*;

`include "bounded_position_deque_assert.svh"

  logic [1:0]  status;
  logic [8:0]  size;
  logic [47:0] ends;
  logic        in_word;

  assign status  = m_tdata[OUT_STATUS_LO +: 2];
  assign size    = m_tdata[OUT_SIZE_LO +: 9];
  assign ends    = m_tdata[OUT_HEAD_LO +: 48];
  assign in_word = s_tvalid && (s_tdata != '0 || s_tdata == '0);

  // A waiting result holds.
  `BPD_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // No new word is taken while a result is still waiting.
  `BPD_ASSERT_IMP(a_no_take, m_tvalid && !m_tready, !s_tready, "word taken over waiting result")

  // Every word taken either shows a result next or keeps the input closed.
  `BPD_ASSERT_NXT(a_progress, in_word && s_tready, m_tvalid || !s_tready, "word taken and lost")

  // An empty list shows zero head and tail entries.
  `BPD_ASSERT_IMP(a_empty_zero, m_tvalid && size == 9'd0, ends == '0, "empty list shows entries")

  // A refused insert only happens on a full list.
  `BPD_ASSERT_IMP(a_full_size, m_tvalid && status == STATUS_FULL, size == 9'(DEPTH),
                  "full status with room left")

endmodule

bind bounded_position_deque bpd_check #(.DEPTH(DEPTH)) u_bpd_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

### sim/tb.sv
module tb;
  import bpd_pkg::*;

  localparam int RING_SLOTS = DEPTH_DEF;
  localparam int RANDOM_CMDS = 1600;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int MAX_PRINTED = 30;

  // Command codes past the defined set; the deque must leave itself alone.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sym;
  } entry_t;

  typedef struct packed {
    logic [2:0] op;
    entry_t     ent;
    logic [9:0] idx;
  } dq_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] count;
    entry_t     elem;
    entry_t     head;
    entry_t     tail;
  } dq_answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;

  // Commands waiting to be sent and the answers expected back, in order.
  dq_cmd_t    cmd_q[$];
  dq_answer_t answer_q[$];

  // Our own copy of the deque.
  entry_t ring [RING_SLOTS];
  int     ring_head = 0;
  int     ring_count = 0;

  // Entry count as the stimulus will leave it, used to steer the phases.
  int gen_count = 0;

  int      cmds_total = 0;
  int      cmds_taken = 0;
  int      results_seen = 0;
  int      errors = 0;
  int      cycles = 0;
  dq_cmd_t cur_cmd;
  int      burst_left = 1;
  int      gap_left = 0;
  int      pace_mode = 0;
  int      pace_left = 0;
  int      pace_tick = 0;

  bounded_position_deque dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Apply one command to the local deque and work out the answer word.
  function automatic dq_answer_t apply_cmd(input dq_cmd_t c);
    dq_answer_t a;
    int pos;
    a = '0;
    a.status = STATUS_DONE;
    case (c.op)
      CMD_INS_HEAD: begin
        if (ring_count >= RING_SLOTS) begin
          a.status = STATUS_FULL;
        end else begin
          ring_head = (ring_head + RING_SLOTS - 1) % RING_SLOTS;
          ring[ring_head] = c.ent;
          ring_count++;
        end
      end
      CMD_INS_TAIL: begin
        if (ring_count >= RING_SLOTS) begin
          a.status = STATUS_FULL;
        end else begin
          ring[(ring_head + ring_count) % RING_SLOTS] = c.ent;
          ring_count++;
        end
      end
      CMD_RM_HEAD: begin
        if (ring_count == 0) begin
          a.status = STATUS_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % RING_SLOTS;
          ring_count--;
        end
      end
      CMD_RM_TAIL: begin
        if (ring_count == 0) a.status = STATUS_EMPTY;
        else ring_count--;
      end
      CMD_READ: begin
        if (ring_count == 0) begin
          a.status = STATUS_EMPTY;
        end else begin
          // A negative index reads the head, one at or past the end the tail.
          if (c.idx[9]) pos = 0;
          else if (int'(c.idx) >= ring_count) pos = ring_count - 1;
          else pos = int'(c.idx);
          a.elem = ring[(ring_head + pos) % RING_SLOTS];
        end
      end
      default: ;
    endcase
    a.count = 9'(ring_count);
    if (ring_count != 0) begin
      a.head = ring[ring_head];
      a.tail = ring[(ring_head + ring_count - 1) % RING_SLOTS];
    end
    return a;
  endfunction

  function automatic entry_t unpack_entry(input logic [23:0] w);
    entry_t e;
    e.x = w[7:0];
    e.y = w[15:8];
    e.sym = w[23:16];
    return e;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got)
      note_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                              results_seen, what, want, got));
  endtask

  task automatic check_entry(input string what, input entry_t want, input entry_t got);
    check_field({what, "_x"}, want.x, got.x);
    check_field({what, "_y"}, want.y, got.y);
    check_field({what, "_symbol"}, want.sym, got.sym);
  endtask

  // Queue one command and keep the stimulus-side count in step.
  task automatic queue_cmd(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] s, input logic [9:0] idx);
    dq_cmd_t c;
    c.op = op;
    c.ent.x = x;
    c.ent.y = y;
    c.ent.sym = s;
    c.idx = idx;
    cmd_q.push_back(c);
    cmds_total++;
    if (op == CMD_INS_HEAD || op == CMD_INS_TAIL) begin
      if (gen_count < RING_SLOTS) gen_count++;
    end else if (op == CMD_RM_HEAD || op == CMD_RM_TAIL) begin
      if (gen_count > 0) gen_count--;
    end
  endtask

  // Index mix: negative, past the end, the edges and inside the list.
  function automatic logic [9:0] pick_index(input int cnt);
    case ($urandom_range(0, 9))
      0, 1:    return 10'(-int'($urandom_range(1, 512)));
      2:       return 10'($urandom_range(cnt, 511));
      3:       return 10'(cnt);
      4:       return 10'((cnt > 0) ? cnt - 1 : 0);
      5:       return 10'd0;
      default: return 10'((cnt > 0) ? $urandom_range(0, cnt - 1) : $urandom_range(0, 511));
    endcase
  endfunction

  // Random payload for any command; non-insert commands carry noise.
  task automatic queue_random(input logic [2:0] op);
    queue_cmd(op, 8'($urandom), 8'($urandom), 8'($urandom), pick_index(gen_count));
  endtask

  function automatic logic [2:0] any_insert();
    return $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
  endfunction

  function automatic logic [2:0] any_remove();
    return $urandom_range(0, 1) ? CMD_RM_HEAD : CMD_RM_TAIL;
  endfunction

  // Grow to full with a few reads mixed in, then push against the limit.
  task automatic fill_phase();
    int extra;
    extra = $urandom_range(2, 5);
    while (gen_count < RING_SLOTS) begin
      if ($urandom_range(0, 9) == 0) queue_random(CMD_READ);
      else queue_random(any_insert());
    end
    repeat (extra) queue_random(any_insert());
    queue_random(CMD_READ);
  endtask

  // Shrink to empty, then remove and read on the empty list.
  task automatic drain_phase();
    int extra;
    extra = $urandom_range(2, 4);
    while (gen_count > 0) begin
      if ($urandom_range(0, 9) == 0) queue_random(CMD_READ);
      else queue_random(any_remove());
    end
    repeat (extra) queue_random(any_remove());
    queue_random(CMD_READ);
  endtask

  // Mixed traffic around whatever size the list has reached.
  task automatic walk_phase();
    int n;
    int r;
    n = $urandom_range(40, 150);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 26) queue_random(any_insert());
      else if (r < 50) queue_random(any_remove());
      else if (r < 92) queue_random(CMD_READ);
      else queue_random(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
    end
  endtask

  // Sender: words go out in bursts with random gaps between them.
  always @(posedge clk) begin : cmd_driver
    dq_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        answer_q.push_back(apply_cmd(cur_cmd));
        cmds_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          c = cmd_q.pop_front();
          cur_cmd = c;
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, c.idx, c.ent.sym, c.ent.y, c.ent.x, c.op};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // Receiver: switches between always ready, light and heavy stalls, and a
  // fixed on/off rhythm.
  always @(posedge clk) begin : sink_pacing
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_mode = $urandom_range(0, 3);
        pace_left = $urandom_range(20, 400);
      end else begin
        pace_left--;
      end
      pace_tick++;
      case (pace_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((pace_tick % 7) < 4);
      endcase
    end
  end

  // Compare every accepted result word with the oldest expected answer.
  always @(posedge clk) begin : result_monitor
    dq_answer_t want;
    dq_answer_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[OUT_STATUS_LO +: 2];
      got.count = m_tdata[OUT_SIZE_LO +: 9];
      got.elem = unpack_entry(m_tdata[OUT_ELEM_LO +: 24]);
      got.head = unpack_entry(m_tdata[OUT_HEAD_LO +: 24]);
      got.tail = unpack_entry(m_tdata[OUT_TAIL_LO +: 24]);
      if (answer_q.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with no command outstanding",
                                results_seen));
      end else begin
        want = answer_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("size", want.count, got.count);
        check_entry("elem", want.elem, got.elem);
        check_entry("head", want.head, got.head);
        check_entry("tail", want.tail, got.tail);
      end
      results_seen++;
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;

    // Empty list: reads, removes and spare codes.
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_RM_HEAD, 8'hff, 8'hff, 8'hff, 10'h3ff);
    queue_cmd(CMD_RM_TAIL, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_SPARE_FIRST, 8'h12, 8'h34, 8'h56, 10'd5);
    queue_cmd(CMD_SPARE_FIRST + 3'd1, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_SPARE_LAST, 8'hff, 8'hff, 8'hff, 10'h3ff);
    // Three entries with extreme and alternating payloads.
    queue_cmd(CMD_INS_TAIL, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_INS_HEAD, 8'hff, 8'hff, 8'hff, 10'h3ff);
    queue_cmd(CMD_INS_TAIL, 8'h55, 8'haa, 8'h5a, 10'd0);
    // Reads at each position and clamped on both sides.
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd1);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd2);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd3);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'h3ff);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'h200);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'h1ff);
    queue_cmd(CMD_SPARE_LAST, 8'h77, 8'h88, 8'h99, 10'd1);
    // Take the list back down to empty from both ends.
    queue_cmd(CMD_RM_HEAD, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_RM_TAIL, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_RM_TAIL, 8'h00, 8'h00, 8'h00, 10'd0);
    queue_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd0);

    // Random part: one full fill and drain, then a mix of phases.
    fill_phase();
    drain_phase();
    while (cmds_total < RANDOM_CMDS) begin
      phase = $urandom_range(0, 3);
      if (phase == 0) fill_phase();
      else if (phase == 1) drain_phase();
      else walk_phase();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (cmds_taken < cmds_total || answer_q.size() != 0) @(posedge clk);
    repeat (RING_SLOTS + 16) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
